### rtl/in_order_completion_tracker_macros.svh
// Assertion macros used by the completion tracker top level.
`ifndef IN_ORDER_COMPLETION_TRACKER_MACROS_SVH
`define IN_ORDER_COMPLETION_TRACKER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IOCT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ioct assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define IOCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ioct assertion failed");

`endif

### rtl/ioct_pkg.sv
// Package: types and constants of the in-order completion tracker.
`timescale 1ns / 1ps

package ioct_pkg;

  localparam int MAX_REQUESTS_DEF = 64;
  localparam int IDX_W            = 6;
  localparam int CNT_W            = 7;
  localparam int CFG_IDX_W        = 2;

  // Request modes
  localparam logic MODE_EVENT   = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_RETIRED  = 2'd0;
  localparam logic [1:0] ST_FINISHED = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IN_ORDER     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_REQUESTS = 2'd1;

  localparam logic [CNT_W-1:0] NUM_REQUESTS_RST = 7'd64;

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] request_index;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] retired_index;
    logic [1:0]       status;
    logic             all_done;
    logic             last;
  } out_item_t;

  // Control from the sequencer to the mark memory
  typedef struct packed {
    logic             clr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

endpackage

### rtl/ioct_mark_mem.sv
// Done-mark memory: one bit per request, registered read, valid bits for clear.
`timescale 1ns / 1ps

module ioct_mark_mem #(
  parameter int DEPTH = ioct_pkg::MAX_REQUESTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ioct_pkg::mem_req_t req,
  output logic              mark
);
  import ioct_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic             mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic             rd_q;
  logic             vld_q;
  logic             fwd_q;

  // Storage write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= 1'b1;
    end
    rd_q <= mem[req.rd_addr[AW-1:0]];
  end

  // Entry valid bits; cleared at once by reset or batch restart
  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      vld <= '0;
    end else if (req.wr_en) begin
      vld[req.wr_addr[AW-1:0]] <= 1'b1;
    end
  end

  // Valid and write-forward flags travel with the read data
  always_ff @(posedge clk) begin
    vld_q <= vld[req.rd_addr[AW-1:0]];
    fwd_q <= req.wr_en && (req.wr_addr[AW-1:0] == req.rd_addr[AW-1:0]);
  end

  assign mark = fwd_q | (rd_q & vld_q);

endmodule

### rtl/ioct_ctrl.sv
// Sequencer: checks events, marks them done, walks the retire run, drives results.
`timescale 1ns / 1ps

module ioct_ctrl #(
  parameter int MAX_REQUESTS = ioct_pkg::MAX_REQUESTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  ioct_pkg::in_item_t         request,
  input  logic                       in_order,
  input  logic [ioct_pkg::CNT_W-1:0] num_requests,
  output ioct_pkg::mem_req_t         mem_req,
  input  logic                       mark,
  output logic                       result_valid,
  output ioct_pkg::out_item_t        result
);
  import ioct_pkg::*;

  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_REQUESTS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_WALK = 3'b100
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] ptr, ptr_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] n;
  logic [IDX_W-1:0] idx_q;
  logic             pend_valid, pend_valid_next;
  logic [IDX_W-1:0] pend_idx, pend_idx_next;
  logic             pend_all, pend_all_next;
  logic             emit;
  out_item_t        emit_item;

  // Effective batch size, clamped to 1..MAX_REQUESTS
  always_comb begin
    if (num_requests == '0) begin
      n = CNT_W'(1);
    end else if (num_requests > MAX_N) begin
      n = MAX_N;
    end else begin
      n = num_requests;
    end
  end

  // Saturating handed-out count
  assign cnt_inc = (cnt == '1) ? cnt : cnt + 1'b1;
  assign busy    = (state != S_IDLE);

  // Next-state and result selection
  always_comb begin
    state_next      = state;
    ptr_next        = ptr;
    cnt_next        = cnt;
    pend_valid_next = pend_valid;
    pend_idx_next   = pend_idx;
    pend_all_next   = pend_all;
    emit            = 1'b0;
    emit_item       = '0;
    mem_req         = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          if (request.mode == MODE_RESTART) begin
            mem_req.clr = 1'b1;
            ptr_next    = '0;
            cnt_next    = '0;
          end else begin
            state_next = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        state_next = S_IDLE;
        emit       = 1'b1;
        if (cnt >= n) begin
          emit_item = '{retired_index: '0, status: ST_FINISHED, all_done: 1'b1, last: 1'b1};
        end else if ({1'b0, idx_q} >= n || mark) begin
          emit_item = '{retired_index: idx_q, status: ST_REJECTED, all_done: 1'b0,
                        last: 1'b1};
        end else begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = idx_q;
          if (in_order) begin
            // Results come from the walk; the new mark is forwarded to it
            emit            = 1'b0;
            pend_valid_next = 1'b0;
            state_next      = S_WALK;
          end else begin
            cnt_next  = cnt_inc;
            emit_item = '{retired_index: idx_q, status: ST_RETIRED,
                          all_done: (cnt_inc >= n), last: 1'b1};
          end
        end
      end
      S_WALK: begin
        // One result is held back until the next mark says whether it is the last
        if (ptr < n && mark) begin
          ptr_next        = ptr + 1'b1;
          cnt_next        = cnt_inc;
          emit            = pend_valid;
          emit_item       = '{retired_index: pend_idx, status: ST_RETIRED,
                              all_done: pend_all, last: 1'b0};
          pend_valid_next = 1'b1;
          pend_idx_next   = ptr[IDX_W-1:0];
          pend_all_next   = (cnt_inc >= n);
        end else begin
          emit            = pend_valid;
          emit_item       = '{retired_index: pend_idx, status: ST_RETIRED,
                              all_done: pend_all, last: 1'b1};
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Read address: the event index on accept, else the retire pointer
    mem_req.rd_addr = (state == S_IDLE) ? request.request_index : ptr_next[IDX_W-1:0];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ptr          <= '0;
      cnt          <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      ptr          <= ptr_next;
      cnt          <= cnt_next;
      pend_valid   <= pend_valid_next;
      result_valid <= emit;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      idx_q <= request.request_index;
    end
    pend_idx <= pend_idx_next;
    pend_all <= pend_all_next;
    if (emit) begin
      result <= emit_item;
    end
  end

endmodule

### rtl/in_order_completion_tracker.sv
// Top level of the in-order completion tracker.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------
//  request  | start, busy             | request (in_item_t)
//  result   | result_valid (strobe)   | result (out_item_t)
//  config   | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
// Request accepted when start is high and busy is low. A restart gives no
// result. An event is looked up in the mark memory in the cycle after
// acceptance; a lone result is then registered onto result_valid and result.
// An in-order walk reads one mark per cycle from the memory port; its results
// leave back to back, and busy stays high until the walk ends.
// Synchronous reset clears control and valid state at once (no clearing pass).
// The result strobe lasts one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps
`include "in_order_completion_tracker_macros.svh"

module in_order_completion_tracker #(
  parameter int MAX_REQUESTS = ioct_pkg::MAX_REQUESTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  ioct_pkg::in_item_t             request,
  output logic                           result_valid,
  output ioct_pkg::out_item_t            result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ioct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ioct_pkg::CNT_W-1:0]     cfg_data
);
  import ioct_pkg::*;

  logic             in_order;
  logic [CNT_W-1:0] num_requests;
  mem_req_t         mem_req;
  logic             mark;
  logic             acc_event;
  logic             acc_restart;
  logic             res_single;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_order     <= 1'b0;
      num_requests <= NUM_REQUESTS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IN_ORDER:     in_order     <= cfg_data[0];
        REG_NUM_REQUESTS: num_requests <= cfg_data;
        default: ;
      endcase
    end
  end

  ioct_ctrl #(
    .MAX_REQUESTS(MAX_REQUESTS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .in_order     (in_order),
    .num_requests (num_requests),
    .mem_req      (mem_req),
    .mark         (mark),
    .result_valid (result_valid),
    .result       (result)
  );

  ioct_mark_mem #(
    .DEPTH(MAX_REQUESTS)
  ) u_mark_mem (
    .clk  (clk),
    .rst  (rst),
    .req  (mem_req),
    .mark (mark)
  );

  // Terms for the checks below
  assign acc_event   = start && !busy && (request.mode == MODE_EVENT);
  assign acc_restart = start && !busy && (request.mode == MODE_RESTART);
  assign res_single  = (result.status == ST_FINISHED) || (result.status == ST_REJECTED);

  // An event always needs a memory lookup cycle
  `IOCT_ASSERT_NEXT(a_event_busy, acc_event, busy)
  // A restart leaves the block idle with no result
  `IOCT_ASSERT_NEXT(a_restart_quiet, acc_restart, !busy && !result_valid)
  // Finished and rejected results are single and final
  `IOCT_ASSERT_IMPL(a_single_last, result_valid && res_single, result.last)
  // A retire run leaves back to back until its last result
  `IOCT_ASSERT_NEXT(a_run_contiguous, result_valid && !result.last, result_valid)

endmodule

### test/in_order_completion_tracker_tb.sv
// Testbench: directed request table, then random batches, checked by an in-line tracker model.
`timescale 1ns / 1ps

module in_order_completion_tracker_tb;
  import ioct_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 240;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 2000;
  // Index past the end of the register list; writes to it change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum bit {ROW_CFG, ROW_REQ} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CNT_W-1:0]      reg_val;
    in_item_t              req;
    bit                    typed;
    out_item_t             res;
  } table_row_t;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 start        = 1'b0;
  logic                 busy;
  in_item_t             request      = '0;
  logic                 result_valid;
  out_item_t            result;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CNT_W-1:0]     cfg_data     = '0;

  // Tracker model state and configuration
  bit                   marks [MAX_REQUESTS_DEF];
  logic [CNT_W-1:0]     retire_ptr;
  logic [CNT_W-1:0]     handout_cnt;
  logic [CNT_W-1:0]     num_req_reg;
  bit                   in_order_reg;

  out_item_t            item_handouts[$];
  out_item_t            pending_handouts[$];
  table_row_t           directed_rows[$];
  int                   errors      = 0;
  int                   items_sent  = 0;
  int                   cycle_count = 0;
  bit                   no_idle     = 1'b0;

  in_order_completion_tracker u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t ns mismatch: %s got %0d want %0d", $time, what, got, want);
    errors++;
  endtask

  function automatic out_item_t handout(logic [IDX_W-1:0] idx, logic [1:0] st,
                                        logic all, logic fin);
    out_item_t r;
    r.retired_index = idx;
    r.status        = st;
    r.all_done      = all;
    r.last          = fin;
    return r;
  endfunction

  function automatic in_item_t request_of(logic mode, logic [IDX_W-1:0] idx);
    in_item_t r;
    r.mode          = mode;
    r.request_index = idx;
    return r;
  endfunction

  // Append one hand-out to the list of the current request
  function automatic void note_handout(out_item_t h);
    item_handouts.insert(item_handouts.size(), h);
  endfunction

  // Effective batch size: 0 acts as 1, anything above the maximum is clamped
  function automatic int batch_len();
    if (num_req_reg == '0) return 1;
    if (int'(num_req_reg) > MAX_REQUESTS_DEF) return MAX_REQUESTS_DEF;
    return int'(num_req_reg);
  endfunction

  function automatic void clear_batch();
    foreach (marks[i]) marks[i] = 1'b0;
    retire_ptr  = '0;
    handout_cnt = '0;
  endfunction

  function automatic void bump_count();
    if (handout_cnt < 7'd127) handout_cnt++;
  endfunction

  // Work out the hand-outs that one accepted request causes
  function automatic void predict_handouts(in_item_t it);
    int               n;
    logic [CNT_W-1:0] p;
    out_item_t        tail;
    n = batch_len();
    item_handouts.delete();
    if (it.mode == MODE_RESTART) begin
      clear_batch();
      return;
    end
    if (int'(handout_cnt) >= n) begin
      note_handout(handout('0, ST_FINISHED, 1'b1, 1'b1));
      return;
    end
    if (int'(it.request_index) >= n || marks[it.request_index]) begin
      note_handout(handout(it.request_index, ST_REJECTED, 1'b0, 1'b1));
      return;
    end
    marks[it.request_index] = 1'b1;
    if (in_order_reg) begin
      // Walk the contiguous done run at the pointer
      while (int'(retire_ptr) < n && marks[retire_ptr[IDX_W-1:0]]) begin
        p = retire_ptr;
        retire_ptr++;
        bump_count();
        note_handout(handout(p[IDX_W-1:0], ST_RETIRED, int'(handout_cnt) >= n, 1'b0));
      end
      if (item_handouts.size() > 0) begin
        tail = item_handouts.pop_back();
        tail.last = 1'b1;
        note_handout(tail);
      end
    end else begin
      bump_count();
      note_handout(handout(it.request_index, ST_RETIRED, int'(handout_cnt) >= n, 1'b1));
    end
  endfunction

  // Mostly short gaps, a few long ones, none in a no-idle stretch
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // Drive one request, wait for acceptance, record what it should produce
  task automatic issue(in_item_t it, bit typed = 1'b0, out_item_t typed_res = '0);
    int unsigned gap;
    start   <= 1'b1;
    request <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_handouts(it);
    if (typed) begin
      pending_handouts.insert(pending_handouts.size(), typed_res);
    end else begin
      foreach (item_handouts[i])
        pending_handouts.insert(pending_handouts.size(), item_handouts[i]);
    end
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Let the block go idle before a register write
  task automatic quiesce();
    start <= 1'b0;
    while (pending_handouts.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; hold keeps valid up for a write that follows at once
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val, bit hold);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (!hold) cfg_valid <= 1'b0;
    if (idx == REG_IN_ORDER) in_order_reg = val[0];
    else if (idx == REG_NUM_REQUESTS) num_req_reg = val;
  endtask

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
    table_row_t row;
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.reg_val = val;
    row.req     = '0;
    row.typed   = 1'b0;
    row.res     = '0;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic void add_req(logic mode, logic [IDX_W-1:0] idx, bit typed = 1'b0,
                                  out_item_t res = '0);
    table_row_t row;
    row.kind    = ROW_REQ;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.req     = request_of(mode, idx);
    row.typed   = typed;
    row.res     = res;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Result checker: each strobe against the oldest pending hand-out
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid) begin
      if (pending_handouts.size() == 0) begin
        report_mismatch("result with nothing pending, index", result.retired_index, -1);
      end else begin
        want = pending_handouts.pop_front();
        if (result.retired_index !== want.retired_index)
          report_mismatch("retired_index", result.retired_index, want.retired_index);
        if (result.status !== want.status)
          report_mismatch("status", result.status, want.status);
        if (result.all_done !== want.all_done)
          report_mismatch("all_done", result.all_done, want.all_done);
        if (result.last !== want.last)
          report_mismatch("last", result.last, want.last);
      end
    end
  end

  initial begin
    int        n;
    int        k;
    int        j;
    int        tmp;
    int        r;
    int        target;
    int        drain;
    int        order[$];
    bit        prev_req;
    bit        hold;
    out_item_t want;

    in_order_reg = 1'b0;
    num_req_reg  = NUM_REQUESTS_RST;
    clear_batch();

    // Any-order defaults: plain retire, duplicate, top index
    add_req(MODE_EVENT, 6'd0, 1'b1, handout(6'd0, ST_RETIRED, 1'b0, 1'b1));
    add_req(MODE_EVENT, 6'd0, 1'b1, handout(6'd0, ST_REJECTED, 1'b0, 1'b1));
    add_req(MODE_EVENT, 6'd63, 1'b1, handout(6'd63, ST_RETIRED, 1'b0, 1'b1));
    // Batch size zero acts as one, already finished
    add_cfg(REG_NUM_REQUESTS, 7'd0);
    add_req(MODE_EVENT, 6'd5, 1'b1, handout(6'd0, ST_FINISHED, 1'b1, 1'b1));
    add_req(MODE_RESTART, 6'd63);
    add_req(MODE_EVENT, 6'd1, 1'b1, handout(6'd1, ST_REJECTED, 1'b0, 1'b1));
    add_req(MODE_EVENT, 6'd0, 1'b1, handout(6'd0, ST_RETIRED, 1'b1, 1'b1));
    add_req(MODE_EVENT, 6'd0, 1'b1, handout(6'd0, ST_FINISHED, 1'b1, 1'b1));
    // Oversized batch clamps; in-order with held-back marks
    add_cfg(REG_NUM_REQUESTS, 7'd127);
    add_cfg(REG_IN_ORDER, 7'd1);
    add_req(MODE_RESTART, 6'd0);
    add_req(MODE_EVENT, 6'd2);
    add_req(MODE_EVENT, 6'd1);
    add_req(MODE_EVENT, 6'd0);
    add_req(MODE_EVENT, 6'd3);
    add_req(MODE_EVENT, 6'd63);
    // Batch lowered to the count: finished
    add_cfg(REG_NUM_REQUESTS, 7'd4);
    add_req(MODE_EVENT, 6'd10, 1'b1, handout(6'd0, ST_FINISHED, 1'b1, 1'b1));
    // Mode switched within the batch
    add_cfg(REG_NUM_REQUESTS, 7'd64);
    add_cfg(REG_IN_ORDER, 7'd0);
    add_req(MODE_EVENT, 6'd5, 1'b1, handout(6'd5, ST_RETIRED, 1'b0, 1'b1));
    add_req(MODE_EVENT, 6'd63, 1'b1, handout(6'd63, ST_REJECTED, 1'b0, 1'b1));
    add_cfg(REG_IN_ORDER, 7'd1);
    add_req(MODE_EVENT, 6'd4);
    add_cfg(REG_UNUSED, 7'd127);
    // Two-entry batch finished by an in-order walk
    add_cfg(REG_NUM_REQUESTS, 7'd2);
    add_req(MODE_RESTART, 6'd42);
    add_req(MODE_EVENT, 6'd1);
    add_req(MODE_EVENT, 6'd0);
    add_req(MODE_EVENT, 6'd21, 1'b1, handout(6'd0, ST_FINISHED, 1'b1, 1'b1));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part
    prev_req = 1'b1;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        if (prev_req) quiesce();
        hold = (i + 1 < directed_rows.size()) && (directed_rows[i + 1].kind == ROW_CFG);
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val, hold);
        prev_req = 1'b0;
      end else begin
        issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
        prev_req = 1'b1;
      end
    end

    // Random batches: mostly well-formed permutations with some noise
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      quiesce();
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) begin
        write_reg(REG_IN_ORDER, 7'($urandom_range(0, 127)), 1'b1);
        r = $urandom_range(0, 9);
        if (r < 6) n = $urandom_range(1, 12);
        else if (r < 8) n = MAX_REQUESTS_DEF;
        else if (r == 8) n = $urandom_range(MAX_REQUESTS_DEF + 1, 127);
        else n = 0;
        write_reg(REG_NUM_REQUESTS, 7'(n), 1'b0);
      end
      // Leaving out the restart now and then mixes modes within a batch
      if ($urandom_range(0, 4) != 0)
        issue(request_of(MODE_RESTART, 6'($urandom_range(0, 63))));
      n = batch_len();

      order.delete();
      if ($urandom_range(0, 3) == 0) begin
        for (k = n - 1; k >= 0; k--) order.insert(order.size(), k);
      end else begin
        for (k = 0; k < n; k++) order.insert(order.size(), k);
        for (k = n - 1; k > 0; k--) begin
          j = $urandom_range(0, k);
          tmp = order[k];
          order[k] = order[j];
          order[j] = tmp;
        end
      end

      for (k = 0; k < n && items_sent < target; k++) begin
        r = $urandom_range(0, 99);
        if (r < 6)
          issue(request_of(MODE_EVENT, 6'($urandom_range(0, 63))));
        else if (r < 11 && k > 0)
          issue(request_of(MODE_EVENT, 6'(order[$urandom_range(0, k - 1)])));
        else if (r < 13)
          issue(request_of(MODE_RESTART, 6'($urandom_range(0, 63))));
        issue(request_of(MODE_EVENT, 6'(order[k])));
      end
      repeat ($urandom_range(0, 2))
        issue(request_of(MODE_EVENT, 6'($urandom_range(0, 63))));
    end

    // Drain and settle
    start <= 1'b0;
    drain = 0;
    while (pending_handouts.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (pending_handouts.size() != 0) begin
      want = pending_handouts.pop_front();
      report_mismatch("result never arrived, index", -1, want.retired_index);
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
